>>> src/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BUI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BUI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bui_pkg.sv
`default_nettype none
package bui_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_SCALE  = 8;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = 11;
  localparam int SCALE_W = 4;
  localparam int DXY_W   = $clog2(MAX_SCALE);
  localparam int COORD_W = 13;
  localparam int DIV_W   = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int WGT_W   = DIV_W;
  localparam int SUM_W   = CH_W + $clog2(MAX_SCALE * MAX_SCALE);
  localparam int REM_W   = SUM_W - CH_W;
  localparam int TAPS    = 4;
  localparam int TAP_W   = 2;
  localparam int DIV_STEPS = CH_W;
  localparam int STEP_W  = 4;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd2;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 11'd400;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 11'd400;

  typedef logic [TAPS-1:0][CH_W-1:0] pix4_t;

  typedef struct packed {
    logic             mac_clr;
    logic             mac_en;
    logic [TAP_W-1:0] tap;
    logic [WGT_W-1:0] wgt;
    logic             div_load;
    logic             div_en;
    logic             div_last;
    logic [DIV_W-1:0] dvsr;
  } lane_ctrl_t;

endpackage
`default_nettype wire

>>> src/bui_line_buf.sv
`default_nettype none
module bui_line_buf
  import bui_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [COL_W-1:0] addr,
  input  wire logic [PIX_W-1:0] wdata,
  output logic      [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];
  logic [PIX_W-1:0] rdata_r;

  // read-first: the old row value comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wdata;
      rdata_r   <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/bui_lane.sv
`default_nettype none
module bui_lane
  import bui_pkg::*;
(
  input  wire logic            clk,
  input  wire lane_ctrl_t      ctrl,
  input  wire pix4_t           pix,
  output logic      [CH_W-1:0] res
);

  logic [SUM_W-1:0]       acc_r;
  logic [REM_W-1:0]       rem_r;
  logic [CH_W-1:0]        q_r;
  logic [CH_W-1:0]        res_r;
  logic [WGT_W+CH_W-1:0]  prod;
  logic [REM_W:0]         trial;
  logic                   ge;
  logic [REM_W-1:0]       rem_nxt;
  logic [CH_W-1:0]        q_nxt;
  logic [DIV_W-1:0]       twice;
  logic                   inc;

  assign prod = (WGT_W+CH_W)'(ctrl.wgt) * (WGT_W+CH_W)'(pix[ctrl.tap]);

  // restoring division, one quotient bit per step
  assign trial   = {rem_r, q_r[CH_W-1]};
  assign ge      = DIV_W'(trial) >= ctrl.dvsr;
  assign rem_nxt = ge ? REM_W'(trial - (REM_W+1)'(ctrl.dvsr)) : trial[REM_W-1:0];
  assign q_nxt   = {q_r[CH_W-2:0], ge};

  // round half to even
  assign twice = DIV_W'({rem_nxt, 1'b0});
  assign inc   = (twice > ctrl.dvsr) || ((twice == ctrl.dvsr) && q_nxt[0]);

  always_ff @(posedge clk) begin
    if (ctrl.mac_clr) begin
      acc_r <= '0;
    end else if (ctrl.mac_en) begin
      acc_r <= acc_r + SUM_W'(prod);
    end
    if (ctrl.div_load) begin
      rem_r <= acc_r[SUM_W-1:CH_W];
      q_r   <= acc_r[CH_W-1:0];
    end else if (ctrl.div_en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
    if (ctrl.div_en && ctrl.div_last) begin
      res_r <= (inc && (q_nxt != '1)) ? q_nxt + CH_W'(1) : q_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> src/bilinear_integer_upscaler_core.sv
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall   chan_zero, chan_one, chan_two
// out_      output     out_valid/out_stall dest_x, dest_y, out_zero/one/two, run_end
// cfg_      input      cfg_wr_en           cfg_index, cfg_wdata
//
// a source pixel that closes no block passes only the read state; one that closes a
// block gives s*s results, each through the weight, multiply-accumulate, divide
// and output states of the three shared channel lanes; output stalls hold the output state
// in_stall is high after the accept until every result of that pixel is taken
// rst_n is synchronous; the line buffer is not cleared and has no clearing pass
`default_nettype none
module bilinear_integer_upscaler_core
  import bui_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CH_W-1:0]    in_chan_zero,
  input  wire logic [CH_W-1:0]    in_chan_one,
  input  wire logic [CH_W-1:0]    in_chan_two,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [COORD_W-1:0] out_dest_x,
  output logic      [COORD_W-1:0] out_dest_y,
  output logic      [CH_W-1:0]    out_zero,
  output logic      [CH_W-1:0]    out_one,
  output logic      [CH_W-1:0]    out_two,
  output logic                    out_run_end,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [SIZE_W-1:0]  cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_WGT  = 6'b000100,
    ST_MAC  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SCALE_W-1:0] scale_r;
  logic [SIZE_W-1:0]  width_r;
  logic [SIZE_W-1:0]  height_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   bc_r;
  logic [ROW_W-1:0]   br_r;
  logic [PIX_W-1:0]   left_r;
  logic [PIX_W-1:0]   upl_r;
  logic [PIX_W-1:0]   f0_r;
  logic [PIX_W-1:0]   f2_r;
  logic [COORD_W-1:0] bx_r;
  logic [COORD_W-1:0] by_r;
  logic [DIV_W-1:0]   d_r;
  logic [WGT_W-1:0]   w_r [TAPS];
  logic [DXY_W-1:0]   dx_r;
  logic [DXY_W-1:0]   dy_r;
  logic [STEP_W-1:0]  step_r;

  logic               in_acc;
  logic [PIX_W-1:0]   cur_pix;
  logic [PIX_W-1:0]   above;
  logic [SCALE_W-1:0] s_eff;
  logic [SIZE_W-1:0]  wid_eff;
  logic [SIZE_W-1:0]  hei_eff;
  logic [DXY_W-1:0]   s_m1;
  logic [SCALE_W-1:0] wa;
  logic [SCALE_W-1:0] wb;
  logic [SCALE_W-1:0] dx_ext;
  logic [SCALE_W-1:0] dy_ext;
  logic [7:0]         p0, p1, p2, p3;
  logic [7:0]         d_full;
  logic [COORD_W:0]   bx_full;
  logic [COORD_W:0]   by_full;
  logic               has_block;
  logic               last_out;
  lane_ctrl_t         ctrl;
  pix4_t              lane_pix [3];
  logic [CH_W-1:0]    lane_res [3];

  assign in_stall = !state_r[0];
  assign in_acc   = in_valid && !in_stall;
  assign cur_pix  = {in_chan_two, in_chan_one, in_chan_zero};

  assign s_eff   = (scale_r == '0) ? SCALE_W'(1) :
                   (scale_r > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_r;
  assign wid_eff = (width_r < SIZE_W'(2)) ? SIZE_W'(2) :
                   (width_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_r;
  assign hei_eff = (height_r < SIZE_W'(2)) ? SIZE_W'(2) :
                   (height_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_r;
  assign s_m1    = DXY_W'(s_eff - SCALE_W'(1));

  assign dx_ext = SCALE_W'(dx_r);
  assign dy_ext = SCALE_W'(dy_r);
  assign wa     = s_eff - dx_ext;
  assign wb     = s_eff - dy_ext;
  assign p0     = 8'(wa) * 8'(wb);
  assign p1     = 8'(dx_ext) * 8'(wb);
  assign p2     = 8'(wa) * 8'(dy_ext);
  assign p3     = 8'(dx_ext) * 8'(dy_ext);
  assign d_full = 8'(s_eff) * 8'(s_eff);
  assign bx_full = (COORD_W+1)'(s_eff) * (COORD_W+1)'(bc_r - COL_W'(1));
  assign by_full = (COORD_W+1)'(s_eff) * (COORD_W+1)'(br_r - ROW_W'(1));

  assign has_block = (bc_r != '0) && (br_r != '0);
  assign last_out  = (dx_r == s_m1) && (dy_r == s_m1);

  bui_line_buf u_line_buf (
    .clk   (clk),
    .en    (in_acc),
    .addr  (col_r),
    .wdata (cur_pix),
    .rdata (above)
  );

  always_comb begin
    ctrl          = '0;
    ctrl.tap      = step_r[TAP_W-1:0];
    ctrl.wgt      = w_r[step_r[TAP_W-1:0]];
    ctrl.dvsr     = d_r;
    ctrl.mac_clr  = state_r[2];
    ctrl.mac_en   = state_r[3];
    ctrl.div_load = state_r[4] && (step_r == '0);
    ctrl.div_en   = state_r[4] && (step_r != '0);
    ctrl.div_last = (step_r == STEP_W'(DIV_STEPS));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_pix[k] = {left_r[k*CH_W +: CH_W], f2_r[k*CH_W +: CH_W],
                     above[k*CH_W +: CH_W], f0_r[k*CH_W +: CH_W]};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    bui_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .pix  (lane_pix[k]),
      .res  (lane_res[k])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_READ;
      ST_READ: state_nxt = has_block ? ST_WGT : ST_IDLE;
      ST_WGT:  state_nxt = ST_MAC;
      ST_MAC:  if (step_r == STEP_W'(TAPS - 1)) state_nxt = ST_DIV;
      ST_DIV:  if (step_r == STEP_W'(DIV_STEPS)) state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_nxt = last_out ? ST_IDLE : ST_WGT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      scale_r  <= SCALE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
      upl_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SCALE:  scale_r  <= cfg_wdata[SCALE_W-1:0];
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        left_r <= cur_pix;
        if ((SIZE_W'(col_r) + SIZE_W'(1)) >= wid_eff) begin
          col_r <= '0;
          row_r <= ((SIZE_W'(row_r) + SIZE_W'(1)) >= hei_eff) ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (state_r == ST_READ) begin
        upl_r <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f0_r <= upl_r;
      f2_r <= left_r;
      bc_r <= col_r;
      br_r <= row_r;
    end
    case (state_r)
      ST_READ: begin
        bx_r <= bx_full[COORD_W-1:0];
        by_r <= by_full[COORD_W-1:0];
        d_r  <= DIV_W'(d_full);
        dx_r <= '0;
        dy_r <= '0;
      end
      ST_WGT: begin
        w_r[0] <= WGT_W'(p0);
        w_r[1] <= WGT_W'(p1);
        w_r[2] <= WGT_W'(p2);
        w_r[3] <= WGT_W'(p3);
        step_r <= '0;
      end
      ST_MAC: begin
        step_r <= (step_r == STEP_W'(TAPS - 1)) ? '0 : step_r + STEP_W'(1);
      end
      ST_DIV: begin
        step_r <= step_r + STEP_W'(1);
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (dx_r == s_m1) begin
            dx_r <= '0;
            dy_r <= dy_r + DXY_W'(1);
          end else begin
            dx_r <= dx_r + DXY_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = state_r[5];
  assign out_dest_x  = bx_r + COORD_W'(dx_r);
  assign out_dest_y  = by_r + COORD_W'(dy_r);
  assign out_zero    = lane_res[0];
  assign out_one     = lane_res[1];
  assign out_two     = lane_res[2];
  assign out_run_end = last_out;

endmodule
`default_nettype wire

>>> src/bui_checker.sv
`default_nettype none
`include "assert_macros.svh"
module bui_checker
  import bui_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [COORD_W-1:0] out_dest_x,
  input wire logic               out_run_end
);

  // busy right after a pixel is taken
  `BUI_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after input transaction")

  // no input while a result is pending
  `BUI_ASSERT_IMP(a_stall_on_out, clk, rst_n, out_valid, in_stall, "input open while result pending")

  // each result needs fresh computation before the next one shows
  `BUI_ASSERT_NXT(a_out_gap, clk, rst_n, out_valid && !out_stall, !out_valid, "results back to back")

  // stalled result holds
  `BUI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_dest_x) && $stable(out_run_end), "stalled result changed")

endmodule

bind bilinear_integer_upscaler_core bui_checker u_bui_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_dest_x  (out_dest_x),
  .out_run_end (out_run_end)
);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
module tb;
  import bui_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [CH_W-1:0]    ch_zero;
    logic [CH_W-1:0]    ch_one;
    logic [CH_W-1:0]    ch_two;
    logic               run_end;
  } upscaled_px_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CH_W-1:0]    in_chan_zero = '0;
  logic [CH_W-1:0]    in_chan_one = '0;
  logic [CH_W-1:0]    in_chan_two = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] out_dest_x;
  logic [COORD_W-1:0] out_dest_y;
  logic [CH_W-1:0]    out_zero;
  logic [CH_W-1:0]    out_one;
  logic [CH_W-1:0]    out_two;
  logic               out_run_end;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = REG_SCALE;
  logic [SIZE_W-1:0]  cfg_wdata = '0;

  // interpolator state as seen from outside
  logic [PIX_W-1:0]   prev_row [MAX_WIDTH];
  bit                 col_written [MAX_WIDTH];
  logic [PIX_W-1:0]   left_px = '0;
  logic [PIX_W-1:0]   upleft_px = '0;
  int                 col_cnt = 0;
  int                 row_cnt = 0;
  logic [SCALE_W-1:0] scale_reg = SCALE_RST;
  logic [SIZE_W-1:0]  width_reg = WIDTH_RST;
  logic [SIZE_W-1:0]  height_reg = HEIGHT_RST;

  upscaled_px_t       pending_px [$];
  int                 mismatch_count = 0;
  bit                 quiet = 1'b0;
  bit                 tx_idle_on = 1'b1;
  bit                 rx_idle_on = 1'b1;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  int                 rx_gap = 0;

  always #2 clk = ~clk;

  bilinear_integer_upscaler_core i_dut (.*);

  function automatic int limit_range(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CH_W-1:0] blend_chan(input logic [PIX_W-1:0] cur, above,
                                                 input int s, dx, dy, k);
    int sum, d, q, rem;
    sum = (s - dx) * (s - dy) * int'(upleft_px[CH_W*k +: CH_W])
        + dx * (s - dy) * int'(above[CH_W*k +: CH_W])
        + (s - dx) * dy * int'(left_px[CH_W*k +: CH_W])
        + dx * dy * int'(cur[CH_W*k +: CH_W]);
    d = s * s;
    q = sum / d;
    rem = sum % d;
    // round half to even
    if (2 * rem > d || (2 * rem == d && (q % 2) == 1)) q++;
    if (q > 255) q = 255;
    return CH_W'(q);
  endfunction

  function automatic void predict_pixel(input logic [CH_W-1:0] c0, c1, c2);
    int s, wid, hei;
    logic [PIX_W-1:0] cur, above;
    upscaled_px_t px;
    s = limit_range(scale_reg, 1, MAX_SCALE);
    wid = limit_range(width_reg, 2, MAX_WIDTH);
    hei = limit_range(height_reg, 2, MAX_HEIGHT);
    cur = {c2, c1, c0};
    above = prev_row[col_cnt];
    if (row_cnt >= 1 && col_cnt >= 1) begin
      for (int dy = 0; dy < s; dy++) begin
        for (int dx = 0; dx < s; dx++) begin
          px.dest_x = COORD_W'(s * (col_cnt - 1) + dx);
          px.dest_y = COORD_W'(s * (row_cnt - 1) + dy);
          px.ch_zero = blend_chan(cur, above, s, dx, dy, 0);
          px.ch_one = blend_chan(cur, above, s, dx, dy, 1);
          px.ch_two = blend_chan(cur, above, s, dx, dy, 2);
          px.run_end = (dx == s - 1) && (dy == s - 1);
          pending_px.push_back(px);
        end
      end
    end
    upleft_px = above;
    left_px = cur;
    prev_row[col_cnt] = cur;
    col_written[col_cnt] = 1'b1;
    if (col_cnt + 1 >= wid) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= hei) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  function automatic void check_field(input string what, input logic [COORD_W-1:0] want_v,
                                      input logic [COORD_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result();
    upscaled_px_t want;
    if (pending_px.size() == 0) begin
      $display("%0t: transaction with nothing expected, actual x %0d y %0d", $time,
               out_dest_x, out_dest_y);
      mismatch_count++;
      return;
    end
    want = pending_px.pop_front();
    check_field("dest_x", want.dest_x, out_dest_x);
    check_field("dest_y", want.dest_y, out_dest_y);
    check_field("out_zero", want.ch_zero, out_zero);
    check_field("out_one", want.ch_one, out_one);
    check_field("out_two", want.ch_two, out_two);
    check_field("run_end", want.run_end, out_run_end);
  endfunction

  // result side: check, then decide the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(input logic [CH_W-1:0] c0, c1, c2);
    if (!quiet && tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_chan_zero <= c0;
    in_chan_one <= c1;
    in_chan_two <= c2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(c0, c1, c2);
  endtask

  function automatic logic [CH_W-1:0] rand_chan();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return CH_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_px.size() != 0);
  endtask

  // an item with no block may still be in flight after the last result
  task automatic settle();
    drain_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= SIZE_W'(val);
    @(posedge clk);
    case (idx)
      REG_SCALE: scale_reg = SCALE_W'(val);
      REG_WIDTH: width_reg = SIZE_W'(val);
      REG_HEIGHT: height_reg = SIZE_W'(val);
      default: ;
    endcase
  endtask

  task automatic configure(input int scale_val, width_val, height_val, input bit keep_scale);
    if (!keep_scale) write_reg(REG_SCALE, scale_val);
    write_reg(REG_WIDTH, width_val);
    write_reg(REG_HEIGHT, height_val);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_scale();
    int sel, s;
    sel = $urandom_range(0, 9);
    if (sel < 5) s = $urandom_range(1, 2);
    else if (sel < 8) s = $urandom_range(3, 4);
    else if (sel == 8) s = $urandom_range(5, 8);
    else s = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
    // upper data bits are not part of the scale register
    if ($urandom_range(0, 3) == 0) s = s | ($urandom_range(1, 127) << SCALE_W);
    return s;
  endfunction

  // a wider row is only allowed mid-frame where the line buffer is filled
  function automatic int pick_width();
    int sel, w, ready;
    sel = $urandom_range(0, 9);
    if (sel < 7) w = $urandom_range(2, 8);
    else if (sel < 9) w = $urandom_range(9, 40);
    else if ($urandom_range(0, 1)) w = $urandom_range(0, 1);
    else w = $urandom_range(MAX_WIDTH, 2047);
    ready = 0;
    while (ready < MAX_WIDTH && col_written[ready]) ready++;
    if (row_cnt != 0 && limit_range(w, 2, MAX_WIDTH) > ready) w = $urandom_range(2, ready);
    return w;
  endfunction

  function automatic int pick_height();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(2, 6);
    if (sel < 8) return $urandom_range(7, MAX_HEIGHT);
    if ($urandom_range(0, 1)) return $urandom_range(0, 1);
    return $urandom_range(MAX_HEIGHT, 2047);
  endfunction

  task automatic test_reset_scale();
    configure(0, 2, 2, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd255, 8'd3);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd128);
    settle();
  endtask

  task automatic test_scale_limits();
    configure(0, 0, 1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd2, 8'd255);
    settle();
    configure(15, 2, 0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    settle();
  endtask

  task automatic test_wide_row();
    configure(3, 2047, 2047, 1'b0);
    send_random_pixels(6);
    settle();
    // column counter now lies beyond the new width
    configure(4, 3, MAX_HEIGHT, 1'b0);
    send_random_pixels(6);
    settle();
  endtask

  task automatic test_output_backpressure();
    configure(2, 4, 3, 1'b0);
    hold_req = 1'b1;
    send_random_pixels(12);
    settle();
  endtask

  task automatic test_drain_pause();
    send_random_pixels(10);
    drain_results();
    send_random_pixels(10);
    settle();
  endtask

  task automatic test_random_frames();
    int sent, n;
    sent = 0;
    while (sent < 380) begin
      configure(pick_scale(), pick_width(), pick_height(), 1'b0);
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      n = (limit_range(scale_reg, 1, MAX_SCALE) >= 5) ? $urandom_range(4, 16)
                                                      : $urandom_range(10, 50);
      send_random_pixels(n);
      sent += n;
      settle();
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    configure(2, 5, 4, 1'b0);
    send_random_pixels(40);
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_scale();
    test_scale_limits();
    test_wide_row();
    test_output_backpressure();
    test_drain_pause();
    test_random_frames();
    test_quiet_tail();
    drain_results();
    repeat (1000) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
